// ===== hdl/pgs_pkg.sv =====
package pgs_pkg;

  localparam int CNT_W = 16;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 3;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRANSITION_TIMEOUT = 3'd0,
    REG_MIN_OFF            = 3'd1,
    REG_COLD_START         = 3'd2,
    REG_FAILURE_WAIT       = 3'd3,
    REG_OFF_HOLD           = 3'd4
  } cfg_idx_t;

  localparam cnt_t TRANSITION_TIMEOUT_RST = cnt_t'(10);
  localparam cnt_t MIN_OFF_RST            = cnt_t'(15);
  localparam cnt_t COLD_START_RST         = cnt_t'(15);
  localparam cnt_t FAILURE_WAIT_RST       = cnt_t'(7);
  localparam cnt_t OFF_HOLD_RST           = cnt_t'(2);

  typedef struct packed {
    cnt_t transition_timeout;
    cnt_t min_off;
    cnt_t failure_wait;
    cnt_t off_hold;
  } cfg_t;

  typedef struct packed {
    logic action;
    logic pgood_sample;
    logic requested_on;
  } in_item_t;

  typedef struct packed {
    logic enable_out;
    logic pgood_seen;
    logic target_on;
    logic transitioning;
    logic request_pending;
    logic ev_power_lost;
    logic ev_power_good;
    logic ev_on_timeout;
    logic ev_off_timeout;
    logic ev_pgood_failure;
    logic ev_hard_off;
    logic ev_already;
  } res_t;

  typedef struct packed {
    logic pgood;
    logic target;
    logic enable;
    logic in_transition;
    logic failure;
    cnt_t transition_count;
    cnt_t allowed_count;
    logic wait_active;
    cnt_t wait_count;
    logic pending;
    logic pending_value;
    cnt_t hold_count;
  } st_t;

  function automatic cnt_t count_down(cnt_t v);
    return (v != '0) ? v - cnt_t'(1) : v;
  endfunction

endpackage

// ===== hdl/pgs_in_if.sv =====
interface pgs_in_if;
  logic valid;
  logic ready;
  logic action;
  logic pgood_sample;
  logic requested_on;

  modport source (output valid, output action, output pgood_sample, output requested_on,
                  input ready);
  modport sink (input valid, input action, input pgood_sample, input requested_on,
                output ready);
endinterface

// ===== hdl/pgs_out_if.sv =====
interface pgs_out_if;
  logic valid;
  logic ready;
  logic enable_out;
  logic pgood_seen;
  logic target_on;
  logic transitioning;
  logic request_pending;
  logic ev_power_lost;
  logic ev_power_good;
  logic ev_on_timeout;
  logic ev_off_timeout;
  logic ev_pgood_failure;
  logic ev_hard_off;
  logic ev_already;

  modport source (output valid, output enable_out, output pgood_seen, output target_on,
                  output transitioning, output request_pending, output ev_power_lost,
                  output ev_power_good, output ev_on_timeout, output ev_off_timeout,
                  output ev_pgood_failure, output ev_hard_off, output ev_already,
                  input ready);
  modport sink (input valid, input enable_out, input pgood_seen, input target_on,
                input transitioning, input request_pending, input ev_power_lost,
                input ev_power_good, input ev_on_timeout, input ev_off_timeout,
                input ev_pgood_failure, input ev_hard_off, input ev_already,
                output ready);
endinterface

// ===== hdl/chassis_power_good_supervisor.sv =====
// Watches a chassis power-good line and drives the power enable. Each input item is either a
// tick carrying a power-good sample or a power on/off request, and each item returns exactly
// one status item with the enable level, state flags and the events it raised. One item is
// accepted every clock cycle unless the status output stalls; an accepted item is held in the
// input register, the whole supervisor state is updated from it and the status register is
// loaded with its result once the output can take it. The user must write configuration only
// while no item is in flight (unchecked by the block); the cold-start time is applied only at reset.
module chassis_power_good_supervisor (
  input  logic                          clk,
  input  logic                          rst,
  pgs_in_if.sink                        cmd,
  pgs_out_if.source                     status,
  input  logic                          cfg_wr_en,
  input  logic [pgs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pgs_pkg::CFG_W-1:0]     cfg_data
);
  import pgs_pkg::*;

  cfg_t     cfg;
  in_item_t in_item;
  logic     in_valid;
  res_t     res;
  res_t     out_res;
  logic     out_valid;
  logic     advance;

  assign advance = in_valid && (!out_valid || status.ready);
  assign cmd.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      in_item.action <= cmd.action;
      in_item.pgood_sample <= cmd.pgood_sample;
      in_item.requested_on <= cmd.requested_on;
    end
  end

  pgs_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  pgs_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (status.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign status.valid = out_valid;
  assign status.enable_out = out_res.enable_out;
  assign status.pgood_seen = out_res.pgood_seen;
  assign status.target_on = out_res.target_on;
  assign status.transitioning = out_res.transitioning;
  assign status.request_pending = out_res.request_pending;
  assign status.ev_power_lost = out_res.ev_power_lost;
  assign status.ev_power_good = out_res.ev_power_good;
  assign status.ev_on_timeout = out_res.ev_on_timeout;
  assign status.ev_off_timeout = out_res.ev_off_timeout;
  assign status.ev_pgood_failure = out_res.ev_pgood_failure;
  assign status.ev_hard_off = out_res.ev_hard_off;
  assign status.ev_already = out_res.ev_already;

endmodule

// ===== hdl/pgs_cfg_regs.sv =====
module pgs_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [pgs_pkg::CFG_IDX_W-1:0] index,
  input  logic [pgs_pkg::CFG_W-1:0]     data,
  output pgs_pkg::cfg_t                 cfg
);
  import pgs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.transition_timeout <= TRANSITION_TIMEOUT_RST;
      cfg.min_off            <= MIN_OFF_RST;
      cfg.failure_wait       <= FAILURE_WAIT_RST;
      cfg.off_hold           <= OFF_HOLD_RST;
    end else if (wr_en) begin
      case (index)
        REG_TRANSITION_TIMEOUT: cfg.transition_timeout <= cnt_t'(data);
        REG_MIN_OFF:            cfg.min_off            <= cnt_t'(data);
        // The cold-start time only takes effect through reset, which restores its default.
        REG_COLD_START:         cfg.min_off            <= cfg.min_off;
        REG_FAILURE_WAIT:       cfg.failure_wait       <= cnt_t'(data);
        REG_OFF_HOLD:           cfg.off_hold           <= cnt_t'(data);
        default:                cfg.min_off            <= cfg.min_off;
      endcase
    end
  end

endmodule

// ===== hdl/pgs_core.sv =====
module pgs_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  pgs_pkg::in_item_t item,
  input  pgs_pkg::cfg_t     cfg,
  output pgs_pkg::res_t     res
);
  import pgs_pkg::*;

  st_t st;
  st_t st_next;

  function automatic st_t commit(st_t s, logic on, cfg_t c);
    st_t t;
    t = s;
    t.enable = on;
    t.target = on;
    t.in_transition = 1'b1;
    t.transition_count = c.transition_timeout;
    if (!on) begin
      t.allowed_count = c.min_off;
    end
    return t;
  endfunction

  always_comb begin
    st_t  s;
    res_t r;
    s = st;
    r = '0;
    if (item.action) begin
      if (st.pending) begin
        s = st;
      end else if (item.requested_on == st.target) begin
        r.ev_already = 1'b1;
      end else if (!item.requested_on) begin
        if (cfg.off_hold == '0) begin
          s = commit(s, 1'b0, cfg);
        end else begin
          s.pending = 1'b1;
          s.pending_value = 1'b0;
          s.hold_count = cfg.off_hold;
        end
      end else begin
        if (st.allowed_count == '0) begin
          s = commit(s, 1'b1, cfg);
        end else begin
          s.pending = 1'b1;
          s.pending_value = 1'b1;
        end
      end
    end else begin
      s.allowed_count = count_down(st.allowed_count);
      s.hold_count = count_down(st.hold_count);
      if (st.wait_active) begin
        s.wait_count = count_down(st.wait_count);
        if (s.wait_count == '0) begin
          r.ev_hard_off = 1'b1;
          s.wait_active = 1'b0;
        end
      end

      if (st.in_transition && st.transition_count == '0) begin
        s.in_transition = 1'b0;
        r.ev_on_timeout = st.target;
        r.ev_off_timeout = !st.target;
        s.failure = 1'b1;
      end else begin
        if (st.in_transition) begin
          s.transition_count = count_down(st.transition_count);
        end
        if (item.pgood_sample != st.pgood) begin
          s.pgood = item.pgood_sample;
          if (!item.pgood_sample) begin
            r.ev_power_lost = 1'b1;
          end else begin
            r.ev_power_good = 1'b1;
            s.failure = 1'b0;
          end
        end
        if (item.pgood_sample == st.target) begin
          s.in_transition = 1'b0;
        end else if (!st.in_transition && !item.pgood_sample && !s.failure) begin
          s.wait_active = 1'b1;
          s.wait_count = cfg.failure_wait;
          s.failure = 1'b1;
          r.ev_pgood_failure = 1'b1;
        end
      end

      if (st.pending) begin
        if (!st.pending_value && s.hold_count == '0) begin
          s.pending = 1'b0;
          s = commit(s, 1'b0, cfg);
        end else if (st.pending_value && s.allowed_count == '0) begin
          s.pending = 1'b0;
          s = commit(s, 1'b1, cfg);
        end
      end
    end

    r.enable_out = s.enable;
    r.pgood_seen = s.pgood;
    r.target_on = s.target;
    r.transitioning = s.in_transition;
    r.request_pending = s.pending;
    st_next = s;
    res = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.pgood            <= 1'b0;
      st.target           <= 1'b0;
      st.enable           <= 1'b0;
      st.in_transition    <= 1'b0;
      st.failure          <= 1'b0;
      st.transition_count <= '0;
      st.allowed_count    <= COLD_START_RST;
      st.wait_active      <= 1'b0;
      st.wait_count       <= '0;
      st.pending          <= 1'b0;
      st.pending_value    <= 1'b0;
      st.hold_count       <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  a_enable_follows_target: assert property (@(posedge clk) disable iff (rst)
    st.enable == st.target)
    else $error("enable line differs from committed target");

  a_event_exclusive: assert property (@(posedge clk) disable iff (rst)
    advance |-> $onehot0({res.ev_on_timeout, res.ev_off_timeout, res.ev_already}))
    else $error("conflicting events in one item");

  a_timeout_sets_failure: assert property (@(posedge clk) disable iff (rst)
    advance && (res.ev_on_timeout || res.ev_off_timeout) |=> st.failure)
    else $error("transition timeout did not set the failure state");

  a_failure_starts_wait: assert property (@(posedge clk) disable iff (rst)
    advance && res.ev_pgood_failure |=> st.wait_active && st.failure)
    else $error("power good failure did not start the failure wait");

endmodule
